>>> rtl/core/mhtq_pkg.sv
// ----------------------------------------------------------------------------
// mhtq_pkg: shared types and constants of the min-heap timer queue
// Function codes, result kinds, status codes and sequencer states.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int HEAP_DEPTH_DEF = 32;
  localparam int ID_COUNT_DEF   = 1024;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 10;
  localparam int TMO_W    = 31;
  localparam int KIND_W   = 2;
  localparam int DELAY_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_ADJUST = 3'd1,
    FN_FIRE   = 3'd2,
    FN_TICK   = 3'd3,
    FN_NEXT   = 3'd4,
    FN_CLEAR  = 3'd5,
    FN_POP    = 3'd6,
    FN_NOP    = 3'd7
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KD_ACK   = 2'd0,
    KD_FIRED = 2'd1,
    KD_NEXT  = 2'd2,
    KD_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,     // wait for an input transfer
    S_MAP_RD,   // slot map read in flight
    S_DECIDE,   // choose what the operation does
    S_MOVE_RD,  // read the last entry for a removal
    S_MOVE_WR,  // write last entry into the hole
    S_CLR,      // sweep the id map valid bits
    S_DN_RDC,   // sift down: read left child
    S_DN_RDD,   // sift down: read right child
    S_DN_CMP,   // sift down: pick child, compare
    S_DN_WR1,   // swap: write parent slot
    S_DN_WR2,   // swap: write child slot
    S_UP_RD,    // sift up: read parent
    S_UP_CMP,   // sift up: latch parent
    S_UP_WR1,   // swap: write child slot
    S_UP_WR2,   // swap: write parent slot
    S_TOP_RD,   // read the heap top for tick, next or pop
    S_TOP_CHK,  // check top expiry
    S_EMIT,     // hold a result until transferred
    S_FIN       // stash the final result
  } state_t;

endpackage

>>> rtl/core/mhtq_if.sv
// ----------------------------------------------------------------------------
// mhtq_in_if / mhtq_out_if: valid-ready channels of the timer queue
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mhtq_in_if;
  logic                         valid;
  logic                         ready;
  logic [mhtq_pkg::FUNC_W-1:0]  func;
  logic [mhtq_pkg::ID_W-1:0]    timer_id;
  logic [mhtq_pkg::TMO_W-1:0]   timeout_ms;
  modport source (output valid, func, timer_id, timeout_ms, input ready);
  modport sink   (input valid, func, timer_id, timeout_ms, output ready);
endinterface

interface mhtq_out_if;
  logic                           valid;
  logic                           ready;
  logic [mhtq_pkg::KIND_W-1:0]    kind;
  logic [mhtq_pkg::ID_W-1:0]      out_id;
  logic signed [mhtq_pkg::DELAY_W-1:0] delay_ms;
  logic [mhtq_pkg::STATUS_W-1:0]  status;
  logic [mhtq_pkg::OCC_W-1:0]     occupancy;
  logic                           last;
  modport source (output valid, kind, out_id, delay_ms, status, occupancy, last,
                  input ready);
  modport sink   (input valid, kind, out_id, delay_ms, status, occupancy, last,
                  output ready);
endinterface

>>> rtl/core/mhtq_ram.sv
// ----------------------------------------------------------------------------
// mhtq_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/min_heap_timer_queue.sv
// ----------------------------------------------------------------------------
// min_heap_timer_queue: binary min-heap timer queue with id-to-slot map
// Sequencer over heap and map RAMs with a shared time comparator for the sifts.
// ----------------------------------------------------------------------------
// Usage: send operations on the input channel (func, timer_id, timeout_ms).
// Each operation answers with a run of results on the output channel; the
// final one carries last = 1. Fired timers come out as kind 1 results, tick
// and next fire every expired entry before their closing result.
// The block takes one operation at a time; in_ready is high only while the
// sequencer is idle and no result waits. A plain acknowledge passes through
// the map read, decide and final states before its result is registered.
// A sift up reads the parent, compares and swaps by writing the child and
// then the parent slot; a sift down reads both children, picks one, compares
// and swaps likewise (at most log2 of HEAP_DEPTH levels). A removal first
// moves the last entry into the hole; every entry fired by tick or next costs
// one more removal plus its sift. The heap RAMs are single-port, touched
// one word per cycle. Clear sweeps the id valid bits, one id per cycle.
// Reset is synchronous: the heap is empty, time is zero, and a sweep
// clears the id map before the first input is taken.
// When the receiver stalls, the pending result holds in the output register,
// the sequencer waits and the input stays not ready.
// ----------------------------------------------------------------------------
module min_heap_timer_queue #(
  parameter int HEAP_DEPTH = mhtq_pkg::HEAP_DEPTH_DEF,
  parameter int ID_COUNT   = mhtq_pkg::ID_COUNT_DEF,
  parameter int TIME_WIDTH = mhtq_pkg::TIME_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mhtq_in_if.sink    in_ch,
  mhtq_out_if.source out_ch
);

  localparam int SW  = $clog2(HEAP_DEPTH);       // slot index
  localparam int CW  = $clog2(HEAP_DEPTH + 1);   // count
  localparam int IW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int IWC = $clog2(ID_COUNT + 1);
  localparam int EW  = mhtq_pkg::ID_W + TIME_WIDTH; // heap word: id, expiry
  localparam int MW  = SW + 1;                    // map word: valid, slot

  // request latch
  mhtq_pkg::func_t                  func_r, func_nxt;
  logic [mhtq_pkg::ID_W-1:0]        id_r, id_nxt;
  logic [TIME_WIDTH-1:0]            exp_r, exp_nxt;
  logic [TIME_WIDTH-1:0]            now_r, now_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  mhtq_pkg::state_t                 st_r, st_nxt;

  // sift cursor and the entry that travels
  logic [SW:0]                      k_r, k_nxt;      // one extra bit for 2k+1
  logic [SW:0]                      c_r, c_nxt;
  logic [EW-1:0]                    cur_r, cur_nxt;  // entry at slot k
  logic [EW-1:0]                    oth_r, oth_nxt;  // child or parent entry
  logic                             moved_r, moved_nxt;
  logic                             in_fire_r, in_fire_nxt; // tick/next draining
  logic [mhtq_pkg::ID_W-1:0]        fid_r, fid_nxt;  // removed id
  logic [IWC-1:0]                   clr_r, clr_nxt;

  // output register
  logic                             ov_r, ov_nxt;
  mhtq_pkg::kind_t                  ok_r, ok_nxt;
  logic [mhtq_pkg::ID_W-1:0]        oid_r, oid_nxt;
  logic [mhtq_pkg::DELAY_W-1:0]     od_r, od_nxt;
  mhtq_pkg::status_t                os_r, os_nxt;
  logic                             ol_r, ol_nxt;

  // RAM ports
  logic            h_we;
  logic [SW-1:0]   h_addr;
  logic [EW-1:0]   h_wd, h_rd;
  logic            m_we;
  logic [IW-1:0]   m_addr;
  logic [MW-1:0]   m_wd, m_rd;

  mhtq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd)
  );
  mhtq_ram #(.WIDTH(MW), .DEPTH(ID_COUNT)) u_map (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  // shared comparator: a strictly after b
  logic [TIME_WIDTH-1:0] cmp_a, cmp_b, cmp_d;
  logic                  cmp_after;
  assign cmp_d     = cmp_a - cmp_b;
  assign cmp_after = (cmp_d != '0) && !cmp_d[TIME_WIDTH-1];

  function automatic logic [TIME_WIDTH-1:0] exp_of(input logic [EW-1:0] e);
    return e[TIME_WIDTH-1:0];
  endfunction
  function automatic logic [mhtq_pkg::ID_W-1:0] id_of(input logic [EW-1:0] e);
    return e[EW-1:TIME_WIDTH];
  endfunction

  logic id_ok;
  assign id_ok = ({{(32-mhtq_pkg::ID_W){1'b0}}, id_r} < 32'(ID_COUNT));

  logic [TIME_WIDTH-1:0] top_d;
  assign top_d = exp_of(h_rd) - now_r;

  assign in_ch.ready      = (st_r == mhtq_pkg::S_IDLE) && !ov_r;
  assign out_ch.valid     = ov_r;
  assign out_ch.kind      = ok_r;
  assign out_ch.out_id    = oid_r;
  assign out_ch.delay_ms  = od_r;
  assign out_ch.status    = os_r;
  assign out_ch.occupancy = mhtq_pkg::OCC_W'(cnt_r);
  assign out_ch.last      = ol_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; func_nxt = func_r; id_nxt = id_r; exp_nxt = exp_r;
    now_nxt = now_r; cnt_nxt = cnt_r; k_nxt = k_r; c_nxt = c_r;
    cur_nxt = cur_r; oth_nxt = oth_r; moved_nxt = moved_r;
    in_fire_nxt = in_fire_r; fid_nxt = fid_r;
    clr_nxt = clr_r; ov_nxt = ov_r; ok_nxt = ok_r; oid_nxt = oid_r;
    od_nxt = od_r; os_nxt = os_r; ol_nxt = ol_r;
    h_we = 1'b0; h_addr = SW'(k_r); h_wd = cur_r;
    m_we = 1'b0; m_addr = IW'(id_r); m_wd = '0;
    cmp_a = exp_of(cur_r); cmp_b = exp_of(oth_r);

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      mhtq_pkg::S_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          func_nxt = mhtq_pkg::func_t'(in_ch.func);
          id_nxt   = in_ch.timer_id;
          exp_nxt  = now_r + TIME_WIDTH'(in_ch.timeout_ms);
          m_addr   = IW'(in_ch.timer_id);
          in_fire_nxt = 1'b0;
          st_nxt   = mhtq_pkg::S_MAP_RD;
        end
      end
      mhtq_pkg::S_MAP_RD: st_nxt = mhtq_pkg::S_DECIDE;
      mhtq_pkg::S_DECIDE: begin
        // defaults for a one-result acknowledge
        ok_nxt = mhtq_pkg::KD_ACK; oid_nxt = id_r; od_nxt = '0;
        os_nxt = mhtq_pkg::ST_OK; ol_nxt = 1'b1;
        st_nxt = mhtq_pkg::S_FIN;
        moved_nxt = 1'b0;
        unique case (func_r) inside
          mhtq_pkg::FN_ADD, mhtq_pkg::FN_ADJUST: begin
            if (!id_ok) begin
              os_nxt = mhtq_pkg::ST_UNKNOWN;
            end else if (m_rd[SW]) begin
              k_nxt = {1'b0, m_rd[SW-1:0]};
              cur_nxt = {id_r, exp_r};
              h_we = 1'b1; h_addr = m_rd[SW-1:0]; h_wd = {id_r, exp_r};
              st_nxt = mhtq_pkg::S_DN_RDC;
            end else if (func_r == mhtq_pkg::FN_ADJUST) begin
              os_nxt = mhtq_pkg::ST_UNKNOWN;
            end else if (cnt_r >= CW'(HEAP_DEPTH)) begin
              os_nxt = mhtq_pkg::ST_FULL;
            end else begin
              k_nxt = (SW+1)'(cnt_r);
              cur_nxt = {id_r, exp_r};
              h_we = 1'b1; h_addr = SW'(cnt_r); h_wd = {id_r, exp_r};
              m_we = 1'b1; m_wd = {1'b1, SW'(cnt_r)};
              cnt_nxt = cnt_r + 1'b1;
              st_nxt = mhtq_pkg::S_UP_RD;
            end
          end
          mhtq_pkg::FN_FIRE: begin
            if (cnt_r == '0) begin
              os_nxt = mhtq_pkg::ST_EMPTY;
            end else if (!id_ok || !m_rd[SW]) begin
              os_nxt = mhtq_pkg::ST_UNKNOWN;
            end else begin
              ok_nxt = mhtq_pkg::KD_FIRED;
              fid_nxt = id_r;
              k_nxt = {1'b0, m_rd[SW-1:0]};
              h_addr = SW'(cnt_r - 1'b1);
              st_nxt = mhtq_pkg::S_MOVE_RD;
            end
          end
          mhtq_pkg::FN_TICK, mhtq_pkg::FN_NEXT: begin
            if (func_r == mhtq_pkg::FN_TICK) begin
              now_nxt = now_r + 1'b1;
            end
            in_fire_nxt = 1'b1;
            h_addr = '0;
            st_nxt = mhtq_pkg::S_TOP_RD;
          end
          mhtq_pkg::FN_CLEAR: begin
            oid_nxt = '0; cnt_nxt = '0; clr_nxt = '0;
            st_nxt = mhtq_pkg::S_CLR;
          end
          mhtq_pkg::FN_POP: begin
            oid_nxt = '0;
            if (cnt_r == '0) begin
              os_nxt = mhtq_pkg::ST_EMPTY;
            end else begin
              k_nxt = '0; h_addr = '0;
              st_nxt = mhtq_pkg::S_TOP_RD;
            end
          end
          default: oid_nxt = '0;
        endcase
      end
      mhtq_pkg::S_TOP_RD: begin
        h_addr = '0;
        st_nxt = mhtq_pkg::S_TOP_CHK;
      end
      mhtq_pkg::S_TOP_CHK: begin
        if (ov_r && !out_ch.ready) begin
          // hold the top read until the previous result is taken
          h_addr = '0;
        end else if (!in_fire_r) begin
          // pop: removed id is the top
          oid_nxt = id_of(h_rd); fid_nxt = id_of(h_rd);
          h_addr = SW'(cnt_r - 1'b1);
          st_nxt = mhtq_pkg::S_MOVE_RD;
        end else if (cnt_r != '0 &&
                     (top_d == '0 || top_d[TIME_WIDTH-1])) begin
          // expired top fires, then removal, then back here
          ok_nxt = mhtq_pkg::KD_FIRED; oid_nxt = id_of(h_rd); od_nxt = '0;
          os_nxt = mhtq_pkg::ST_OK; ol_nxt = 1'b0;
          fid_nxt = id_of(h_rd); k_nxt = '0; moved_nxt = 1'b0;
          h_addr = SW'(cnt_r - 1'b1);
          st_nxt = mhtq_pkg::S_MOVE_RD;
        end else begin
          ol_nxt = 1'b1; st_nxt = mhtq_pkg::S_FIN;
          if (func_r == mhtq_pkg::FN_TICK) begin
            ok_nxt = mhtq_pkg::KD_ACK; oid_nxt = '0; od_nxt = '0;
            os_nxt = mhtq_pkg::ST_OK;
          end else if (cnt_r == '0) begin
            ok_nxt = mhtq_pkg::KD_NEXT; oid_nxt = '0; od_nxt = '1;
            os_nxt = mhtq_pkg::ST_EMPTY;
          end else begin
            ok_nxt = mhtq_pkg::KD_NEXT; oid_nxt = '0; os_nxt = mhtq_pkg::ST_OK;
            if (TIME_WIDTH > 31 && top_d > TIME_WIDTH'(32'h7FFF_FFFF)) begin
              od_nxt = 32'h7FFF_FFFF;
            end else begin
              od_nxt = 32'(top_d);
            end
          end
        end
      end
      mhtq_pkg::S_MOVE_RD: begin
        // last entry read in flight; drop the removed id from the map
        h_addr = SW'(cnt_r - 1'b1);
        m_we = 1'b1; m_addr = IW'(fid_r); m_wd = '0;
        st_nxt = mhtq_pkg::S_MOVE_WR;
      end
      mhtq_pkg::S_MOVE_WR: begin
        cnt_nxt = cnt_r - 1'b1;
        cur_nxt = h_rd;
        if (k_r < (SW+1)'(cnt_r - 1'b1)) begin
          h_we = 1'b1; h_addr = SW'(k_r); h_wd = h_rd;
          m_we = 1'b1; m_addr = IW'(id_of(h_rd)); m_wd = {1'b1, SW'(k_r)};
          st_nxt = mhtq_pkg::S_DN_RDC;
        end else begin
          st_nxt = mhtq_pkg::S_EMIT;
        end
      end
      mhtq_pkg::S_DN_RDC: begin
        c_nxt = {k_r[SW-1:0], 1'b1};
        if ({k_r, 1'b1} < (SW+2)'(cnt_r)) begin
          h_addr = SW'({k_r[SW-1:0], 1'b1});
          st_nxt = mhtq_pkg::S_DN_RDD;
        end else begin
          st_nxt = moved_r ? mhtq_pkg::S_EMIT : mhtq_pkg::S_UP_RD;
        end
      end
      mhtq_pkg::S_DN_RDD: begin
        oth_nxt = h_rd;
        if ({1'b0, c_r} + 1'b1 < (SW+2)'(cnt_r)) begin
          h_addr = SW'(c_r + 1'b1);
          st_nxt = mhtq_pkg::S_DN_CMP;
        end else begin
          st_nxt = mhtq_pkg::S_DN_CMP;
          c_nxt = c_r;
        end
      end
      mhtq_pkg::S_DN_CMP: begin
        // pick the right child when the left lies after it
        if ({1'b0, c_r} + 1'b1 < (SW+2)'(cnt_r)) begin
          cmp_a = exp_of(oth_r); cmp_b = exp_of(h_rd);
          if (cmp_after) begin
            oth_nxt = h_rd; c_nxt = c_r + 1'b1;
          end
        end
        st_nxt = mhtq_pkg::S_DN_WR1;
      end
      mhtq_pkg::S_DN_WR1: begin
        cmp_a = exp_of(cur_r); cmp_b = exp_of(oth_r);
        if (cmp_after) begin
          h_we = 1'b1; h_addr = SW'(k_r); h_wd = oth_r;
          m_we = 1'b1; m_addr = IW'(id_of(oth_r)); m_wd = {1'b1, SW'(k_r)};
          st_nxt = mhtq_pkg::S_DN_WR2;
        end else begin
          st_nxt = moved_r ? mhtq_pkg::S_EMIT : mhtq_pkg::S_UP_RD;
        end
      end
      mhtq_pkg::S_DN_WR2: begin
        h_we = 1'b1; h_addr = SW'(c_r); h_wd = cur_r;
        m_we = 1'b1; m_addr = IW'(id_of(cur_r)); m_wd = {1'b1, SW'(c_r)};
        k_nxt = c_r; moved_nxt = 1'b1;
        st_nxt = mhtq_pkg::S_DN_RDC;
      end
      mhtq_pkg::S_UP_RD: begin
        if (k_r == '0) begin
          st_nxt = mhtq_pkg::S_EMIT;
        end else begin
          c_nxt = (k_r - 1'b1) >> 1;
          h_addr = SW'((k_r - 1'b1) >> 1);
          st_nxt = mhtq_pkg::S_UP_CMP;
        end
      end
      mhtq_pkg::S_UP_CMP: begin
        oth_nxt = h_rd;
        st_nxt = mhtq_pkg::S_UP_WR1;
      end
      mhtq_pkg::S_UP_WR1: begin
        cmp_a = exp_of(oth_r); cmp_b = exp_of(cur_r);
        if (cmp_after) begin
          h_we = 1'b1; h_addr = SW'(k_r); h_wd = oth_r;
          m_we = 1'b1; m_addr = IW'(id_of(oth_r)); m_wd = {1'b1, SW'(k_r)};
          st_nxt = mhtq_pkg::S_UP_WR2;
        end else begin
          st_nxt = mhtq_pkg::S_EMIT;
        end
      end
      mhtq_pkg::S_UP_WR2: begin
        h_we = 1'b1; h_addr = SW'(c_r); h_wd = cur_r;
        m_we = 1'b1; m_addr = IW'(id_of(cur_r)); m_wd = {1'b1, SW'(c_r)};
        k_nxt = c_r;
        st_nxt = mhtq_pkg::S_UP_RD;
      end
      mhtq_pkg::S_CLR: begin
        m_we = 1'b1; m_addr = IW'(clr_r); m_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IWC'(ID_COUNT - 1)) begin
          st_nxt = (func_r == mhtq_pkg::FN_CLEAR) ? mhtq_pkg::S_FIN
                                                  : mhtq_pkg::S_IDLE;
        end
      end
      mhtq_pkg::S_EMIT: begin
        // heap work done: deliver the pending result
        if (in_fire_r) begin
          if (!ov_r || out_ch.ready) begin
            ov_nxt = 1'b1;
            h_addr = '0;
            st_nxt = mhtq_pkg::S_TOP_RD;
          end
        end else begin
          st_nxt = mhtq_pkg::S_FIN;
        end
      end
      mhtq_pkg::S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          st_nxt = mhtq_pkg::S_IDLE;
        end
      end
      default: st_nxt = mhtq_pkg::S_IDLE;
    endcase
  end

  // state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mhtq_pkg::S_CLR;
      func_r <= mhtq_pkg::FN_NOP;
      cnt_r <= '0; now_r <= '0; clr_r <= '0; ov_r <= 1'b0;
      in_fire_r <= 1'b0; moved_r <= 1'b0;
    end else begin
      st_r <= st_nxt; func_r <= func_nxt; cnt_r <= cnt_nxt; now_r <= now_nxt;
      clr_r <= clr_nxt; ov_r <= ov_nxt; in_fire_r <= in_fire_nxt;
      moved_r <= moved_nxt;
    end
    id_r <= id_nxt; exp_r <= exp_nxt; k_r <= k_nxt; c_r <= c_nxt;
    cur_r <= cur_nxt; oth_r <= oth_nxt; fid_r <= fid_nxt;
    ok_r <= ok_nxt; oid_r <= oid_nxt; od_r <= od_nxt; os_r <= os_nxt;
    ol_r <= ol_nxt;
  end

endmodule

>>> tb/min_heap_timer_queue_test.sv
// ----------------------------------------------------------------------------
// min_heap_timer_queue_test: self-checking bench for the min-heap timer queue
// Drives operations through the input channel, predicts every result with an
// internal heap model and compares each transfer on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module min_heap_timer_queue_test;

  localparam int DEPTH    = mhtq_pkg::HEAP_DEPTH_DEF;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    mhtq_pkg::kind_t                 kind;
    logic [mhtq_pkg::ID_W-1:0]       id;
    logic [31:0]                     delay;
    mhtq_pkg::status_t               status;
    logic [mhtq_pkg::OCC_W-1:0]      occ;
    logic                            last;
  } result_t;

  typedef struct {
    mhtq_pkg::func_t    fn;
    int unsigned        id;
    int unsigned        tmo;
    bit                 has_want;
    mhtq_pkg::kind_t    want_kind;
    mhtq_pkg::status_t  want_status;
  } op_row_t;

  logic clk;
  logic rst_n;

  mhtq_in_if  in_ch ();
  mhtq_out_if out_ch ();

  min_heap_timer_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Predictor state
  logic [mhtq_pkg::ID_W-1:0] q_ids [DEPTH];
  logic [31:0]               q_exp [DEPTH];
  int                        q_slot [1024];
  bit                        q_armed [1024];
  int                        q_count;
  logic [31:0]               q_now;

  result_t           expected_results [$];
  int                errors;
  int                result_count;
  int                fired_count;
  int                idle_cycles;
  bit                allow_gaps;
  bit                hold_off;
  bit                stim_done;
  bit                check_row;
  mhtq_pkg::kind_t   row_kind;
  mhtq_pkg::status_t row_status;

  function automatic bit later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != 0 && !d[31];
  endfunction

  function automatic void swap_entries(int i, int j);
    logic [mhtq_pkg::ID_W-1:0] t_id;
    logic [31:0]               t_e;
    t_id = q_ids[i];
    t_e  = q_exp[i];
    q_ids[i] = q_ids[j];
    q_exp[i] = q_exp[j];
    q_ids[j] = t_id;
    q_exp[j] = t_e;
    q_slot[q_ids[i]] = i;
    q_slot[q_ids[j]] = j;
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!later(q_exp[p], q_exp[i])) break;
      swap_entries(p, i);
      i = p;
    end
  endfunction

  function automatic bit bubble_down(int i, int n);
    int k;
    int c;
    k = i;
    c = 2 * k + 1;
    while (c < n) begin
      if (c + 1 < n && later(q_exp[c], q_exp[c+1])) c++;
      if (!later(q_exp[k], q_exp[c])) break;
      swap_entries(k, c);
      k = c;
      c = 2 * k + 1;
    end
    return k > i;
  endfunction

  function automatic void rearm(int s);
    if (!bubble_down(s, q_count)) bubble_up(s);
  endfunction

  function automatic void take_out(int i);
    int n;
    n = q_count - 1;
    if (i < n) begin
      swap_entries(i, n);
      if (!bubble_down(i, n)) bubble_up(i);
    end
    q_armed[q_ids[n]] = 0;
    q_count = n;
  endfunction

  function automatic void push_result(mhtq_pkg::kind_t k, int unsigned id,
                                      logic [31:0] dl, mhtq_pkg::status_t st,
                                      bit lst);
    result_t r;
    r.kind = k;
    r.id = id[mhtq_pkg::ID_W-1:0];
    r.delay = dl;
    r.status = st;
    r.occ = q_count[mhtq_pkg::OCC_W-1:0];
    r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Fire every entry whose expiry is not after the current time
  function automatic void fire_due();
    logic [31:0]               d;
    logic [mhtq_pkg::ID_W-1:0] top;
    while (q_count > 0) begin
      d = q_exp[0] - q_now;
      if (d != 0 && !d[31]) break;
      top = q_ids[0];
      take_out(0);
      push_result(mhtq_pkg::KD_FIRED, top, 0, mhtq_pkg::ST_OK, 1'b0);
    end
  endfunction

  function automatic void predict_timer_op(mhtq_pkg::func_t fn, int unsigned id,
                                           int unsigned tmo);
    logic [31:0] exp_t;
    logic [31:0] d;
    bit          known;
    int          s;
    known = q_armed[id];
    exp_t = q_now + tmo;
    case (fn)
      mhtq_pkg::FN_ADD: begin
        if (known) begin
          q_exp[q_slot[id]] = exp_t;
          rearm(q_slot[id]);
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_OK, 1'b1);
        end else if (q_count >= DEPTH) begin
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_FULL, 1'b1);
        end else begin
          s = q_count;
          q_count++;
          q_ids[s] = id[mhtq_pkg::ID_W-1:0];
          q_exp[s] = exp_t;
          q_slot[id] = s;
          q_armed[id] = 1;
          bubble_up(s);
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_OK, 1'b1);
        end
      end
      mhtq_pkg::FN_ADJUST: begin
        if (!known) begin
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_UNKNOWN, 1'b1);
        end else begin
          q_exp[q_slot[id]] = exp_t;
          rearm(q_slot[id]);
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_OK, 1'b1);
        end
      end
      mhtq_pkg::FN_FIRE: begin
        if (q_count == 0)
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_EMPTY, 1'b1);
        else if (!known)
          push_result(mhtq_pkg::KD_ACK, id, 0, mhtq_pkg::ST_UNKNOWN, 1'b1);
        else begin
          take_out(q_slot[id]);
          push_result(mhtq_pkg::KD_FIRED, id, 0, mhtq_pkg::ST_OK, 1'b1);
        end
      end
      mhtq_pkg::FN_TICK: begin
        q_now = q_now + 1;
        fire_due();
        push_result(mhtq_pkg::KD_ACK, 0, 0, mhtq_pkg::ST_OK, 1'b1);
      end
      mhtq_pkg::FN_NEXT: begin
        fire_due();
        if (q_count == 0) begin
          push_result(mhtq_pkg::KD_NEXT, 0, 32'hFFFF_FFFF, mhtq_pkg::ST_EMPTY, 1'b1);
        end else begin
          d = q_exp[0] - q_now;
          if (d[31]) d = 0;
          push_result(mhtq_pkg::KD_NEXT, 0, d, mhtq_pkg::ST_OK, 1'b1);
        end
      end
      mhtq_pkg::FN_CLEAR: begin
        foreach (q_armed[i]) q_armed[i] = 0;
        q_count = 0;
        push_result(mhtq_pkg::KD_ACK, 0, 0, mhtq_pkg::ST_OK, 1'b1);
      end
      mhtq_pkg::FN_POP: begin
        if (q_count == 0) push_result(mhtq_pkg::KD_ACK, 0, 0, mhtq_pkg::ST_EMPTY, 1'b1);
        else begin
          d[mhtq_pkg::ID_W-1:0] = q_ids[0];
          take_out(0);
          push_result(mhtq_pkg::KD_ACK, d[mhtq_pkg::ID_W-1:0], 0, mhtq_pkg::ST_OK, 1'b1);
        end
      end
      default: push_result(mhtq_pkg::KD_ACK, 0, 0, mhtq_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold every input at a known value from time zero
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = mhtq_pkg::FN_NOP;
    in_ch.timer_id = '0;
    in_ch.timeout_ms = '0;
    out_ch.ready = 1'b0;
  end

  // Send one operation and predict its results on the transfer
  task automatic send_op(mhtq_pkg::func_t fn, int unsigned id, int unsigned tmo);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.timer_id <= id[mhtq_pkg::ID_W-1:0];
    in_ch.timeout_ms <= tmo[mhtq_pkg::TMO_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    predict_timer_op(fn, id, tmo);
    if (check_row) begin
      if (expected_results[$].kind != row_kind ||
          expected_results[$].status != row_status) begin
        $error("table row: kind exp %0d got %0d, status exp %0d got %0d",
               row_kind, expected_results[$].kind, row_status,
               expected_results[$].status);
        errors++;
      end
    end
    @(negedge clk);
  endtask

  // Random timeout: mostly short so ticks fire entries, sometimes extreme
  function automatic int unsigned pick_timeout();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return $urandom() & 32'h7FFF_FFFF;
      2: return 0;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  // Ids from a small pool so re-arms and fires hit armed timers
  function automatic int unsigned pick_id();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, 40);
  endfunction

  task automatic random_ops(int n);
    int              r;
    mhtq_pkg::func_t fn;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) fn = mhtq_pkg::FN_ADD;
      else if (r < 45) fn = mhtq_pkg::FN_ADJUST;
      else if (r < 55) fn = mhtq_pkg::FN_FIRE;
      else if (r < 80) fn = mhtq_pkg::FN_TICK;
      else if (r < 90) fn = mhtq_pkg::FN_NEXT;
      else if (r < 92) fn = mhtq_pkg::FN_CLEAR;
      else if (r < 98) fn = mhtq_pkg::FN_POP;
      else fn = mhtq_pkg::FN_NOP;
      send_op(fn, pick_id(), pick_timeout());
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 0;
        out_ch.ready <= 1'b1;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 9);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d id %0d", out_ch.kind, out_ch.out_id);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.kind == mhtq_pkg::KD_FIRED) fired_count++;
        if (out_ch.kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, out_ch.kind); errors++;
        end
        if (out_ch.out_id !== e.id) begin
          $error("out_id: expected %0d, actual %0d", e.id, out_ch.out_id); errors++;
        end
        if (out_ch.delay_ms !== e.delay) begin
          $error("delay_ms: expected %0d, actual %0d", $signed(e.delay), out_ch.delay_ms);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.occupancy !== e.occ) begin
          $error("occupancy: expected %0d, actual %0d", e.occ, out_ch.occupancy); errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_ch.last); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  op_row_t directed [] = '{
    '{mhtq_pkg::FN_NEXT,   0,    0,            1, mhtq_pkg::KD_NEXT,  mhtq_pkg::ST_EMPTY},
    '{mhtq_pkg::FN_POP,    0,    0,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_EMPTY},
    '{mhtq_pkg::FN_FIRE,   5,    0,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_EMPTY},
    '{mhtq_pkg::FN_ADJUST, 5,    7,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_UNKNOWN},
    '{mhtq_pkg::FN_ADD,    0,    0,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_ADD,    1023, 32'h7FFFFFFF, 1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_ADD,    5,    3,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_ADD,    682,  2,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_ADD,    341,  9,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_FIRE,   77,   0,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_UNKNOWN},
    '{mhtq_pkg::FN_NEXT,   0,    0,            0, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_ADJUST, 341,  1,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_ADD,    5,    10,           1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_TICK,   0,    0,            0, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_TICK,   0,    0,            0, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_FIRE,   5,    0,            1, mhtq_pkg::KD_FIRED, mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_NEXT,   0,    0,            0, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_POP,    0,    0,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_NOP,    1,    1,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_CLEAR,  0,    0,            1, mhtq_pkg::KD_ACK,   mhtq_pkg::ST_OK},
    '{mhtq_pkg::FN_NEXT,   0,    0,            1, mhtq_pkg::KD_NEXT,  mhtq_pkg::ST_EMPTY}
  };

  // Main sequence
  initial begin
    int k;
    errors = 0;
    result_count = 0;
    fired_count = 0;
    idle_cycles = 0;
    allow_gaps = 0;
    hold_off = 0;
    check_row = 0;
    q_count = 0;
    q_now = 0;
    foreach (q_armed[i]) q_armed[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed[i]) begin
      check_row = directed[i].has_want;
      row_kind = directed[i].want_kind;
      row_status = directed[i].want_status;
      send_op(directed[i].fn, directed[i].id, directed[i].tmo);
    end
    check_row = 0;

    // Fill the heap to full and probe the full flag
    for (k = 100; k < 100 + DEPTH + 1; k++)
      send_op(mhtq_pkg::FN_ADD, k, $urandom_range(0, 40));
    send_op(mhtq_pkg::FN_ADD, 999, 5);

    // Long receiver hold-off while the sender keeps offering ticks
    hold_off = 1;
    repeat (6) send_op(mhtq_pkg::FN_TICK, 0, 0);
    send_op(mhtq_pkg::FN_CLEAR, 0, 0);

    // Random part with idling, then a closing stretch without it
    allow_gaps = 1;
    random_ops(60);
    allow_gaps = 0;
    random_ops(20);
    repeat (20) send_op(mhtq_pkg::FN_TICK, 0, 0);
    in_ch.valid <= 1'b0;

    // Drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d results (%0d fired timers) across all operations,", result_count,
             fired_count);
    $display("including full heap, unknown ids, empty heap and time extremes.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
